### hdl/aws_pkg.sv
// ============================================================================
// aws_pkg
// Shared types and constants for the sliding-window anagram search.
// ============================================================================
`default_nettype none

package aws_pkg;

    localparam int MAX_PATTERN = 256;
    localparam int ALPHABET    = 26;

    localparam int LETTER_W = 5;
    localparam int CNT_W    = $clog2(MAX_PATTERN + 1);
    localparam int POS_W    = $clog2(MAX_PATTERN);

    typedef enum logic [0:0] {
        OP_PATTERN = 1'b0,
        OP_TEXT    = 1'b1
    } t_op;

    typedef struct packed {
        t_op                 operation;
        logic [LETTER_W-1:0] letter;
        logic                last;
    } t_in_item;

    typedef struct packed {
        logic found;
        logic overflow;
    } t_out_item;

endpackage

`default_nettype wire

### hdl/aws_ram.sv
// ============================================================================
// aws_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module aws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/anagram_window_search.sv
// ============================================================================
// anagram_window_search
// Pattern letters build a histogram; text letters slide a window of pattern
// length; the last text letter reports any full-window match and overflow.
// ============================================================================
// The result is registered and appears on o_out_valid in the cycle after the
// final text item is accepted. Throughput: one item per cycle while ready, set
// by the combinational histogram update and compare; the ring memory read is
// prefetched at the next ring slot. Reset (synchronous) clears both histograms
// and all counters at once; the ring memory is not cleared and needs no pass.
`default_nettype none

module anagram_window_search (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire aws_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output aws_pkg::t_out_item     o_out_data
);

    logic [aws_pkg::CNT_W-1:0]    r_pat_cnt [aws_pkg::ALPHABET];
    logic [aws_pkg::CNT_W-1:0]    r_win_cnt [aws_pkg::ALPHABET];
    logic [aws_pkg::CNT_W-1:0]    n_pat_cnt [aws_pkg::ALPHABET];
    logic [aws_pkg::CNT_W-1:0]    n_win_cnt [aws_pkg::ALPHABET];
    logic [aws_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [aws_pkg::CNT_W-1:0]    r_pat_len, n_pat_len;
    logic [aws_pkg::CNT_W-1:0]    r_text_seen, n_text_seen;
    logic                         r_match, n_match;
    logic                         r_ovf, n_ovf;
    logic                         r_out_valid;
    aws_pkg::t_out_item           r_out;
    logic                         r_byp;
    logic [aws_pkg::LETTER_W-1:0] r_byp_data;

    logic                         accept;
    logic                         is_text;
    logic                         letter_ok;
    logic                         gives_result;
    logic                         take;
    logic                         pat_take;
    logic                         full;
    logic                         hist_eq;
    logic                         match_set;
    logic [aws_pkg::LETTER_W-1:0] ram_rdata;
    logic [aws_pkg::LETTER_W-1:0] old_letter;
    logic [aws_pkg::CNT_W-1:0]    pos_inc;

    // a result-bearing item waits only for a free output register
    assign o_in_ready = !(i_in_data.operation == aws_pkg::OP_TEXT && i_in_data.last)
                        || !r_out_valid || i_out_ready;
    assign accept       = i_in_valid && o_in_ready;
    assign is_text      = (i_in_data.operation == aws_pkg::OP_TEXT);
    assign letter_ok    = (i_in_data.letter < aws_pkg::LETTER_W'(aws_pkg::ALPHABET));
    assign gives_result = is_text && i_in_data.last;
    assign full         = (r_text_seen == r_pat_len);
    assign take         = accept && is_text && letter_ok && (r_pat_len != '0);
    assign pat_take     = accept && !is_text && letter_ok && (r_text_seen == '0);
    assign old_letter   = r_byp ? r_byp_data : ram_rdata;
    assign pos_inc      = {1'b0, r_pos} + aws_pkg::CNT_W'(1);

    aws_ram #(
        .WIDTH (aws_pkg::LETTER_W),
        .DEPTH (aws_pkg::MAX_PATTERN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (take),
        .i_waddr (r_pos),
        .i_wdata (i_in_data.letter),
        .i_raddr (n_pos),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_pat_len   = r_pat_len;
        n_ovf       = r_ovf;
        n_text_seen = r_text_seen;
        n_pos       = r_pos;
        hist_eq     = 1'b1;
        for (int k = 0; k < aws_pkg::ALPHABET; k++) begin
            n_pat_cnt[k] = r_pat_cnt[k];
            n_win_cnt[k] = r_win_cnt[k];
        end

        if (pat_take) begin
            if (r_pat_len < aws_pkg::CNT_W'(aws_pkg::MAX_PATTERN)) begin
                n_pat_len = r_pat_len + aws_pkg::CNT_W'(1);
                for (int k = 0; k < aws_pkg::ALPHABET; k++) begin
                    if (i_in_data.letter == aws_pkg::LETTER_W'(k)) begin
                        n_pat_cnt[k] = r_pat_cnt[k] + aws_pkg::CNT_W'(1);
                    end
                end
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (take) begin
            if (!full) begin
                n_text_seen = r_text_seen + aws_pkg::CNT_W'(1);
            end
            for (int k = 0; k < aws_pkg::ALPHABET; k++) begin
                n_win_cnt[k] = r_win_cnt[k]
                    + aws_pkg::CNT_W'(i_in_data.letter == aws_pkg::LETTER_W'(k))
                    - aws_pkg::CNT_W'(full && old_letter == aws_pkg::LETTER_W'(k)
                                      && r_win_cnt[k] != '0);
            end
            n_pos = (pos_inc == r_pat_len) ? '0 : pos_inc[aws_pkg::POS_W-1:0];
        end

        for (int k = 0; k < aws_pkg::ALPHABET; k++) begin
            hist_eq = hist_eq && (r_pat_cnt[k] == n_win_cnt[k]);
        end
        match_set = accept && is_text && (letter_ok || i_in_data.last)
                    && (n_text_seen == r_pat_len) && hist_eq;
        n_match   = r_match || match_set;

        // end of query: clear for the next one
        if (accept && gives_result) begin
            n_pat_len   = '0;
            n_ovf       = 1'b0;
            n_text_seen = '0;
            n_pos       = '0;
            n_match     = 1'b0;
            for (int k = 0; k < aws_pkg::ALPHABET; k++) begin
                n_pat_cnt[k] = '0;
                n_win_cnt[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len   <= '0;
            r_ovf       <= 1'b0;
            r_text_seen <= '0;
            r_pos       <= '0;
            r_match     <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp       <= 1'b0;
            for (int k = 0; k < aws_pkg::ALPHABET; k++) begin
                r_pat_cnt[k] <= '0;
                r_win_cnt[k] <= '0;
            end
        end else begin
            r_pat_len   <= n_pat_len;
            r_ovf       <= n_ovf;
            r_text_seen <= n_text_seen;
            r_pos       <= n_pos;
            r_match     <= n_match;
            r_byp       <= take && (r_pos == n_pos);
            for (int k = 0; k < aws_pkg::ALPHABET; k++) begin
                r_pat_cnt[k] <= n_pat_cnt[k];
                r_win_cnt[k] <= n_win_cnt[k];
            end
            if (accept && gives_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_byp_data <= i_in_data.letter;
        if (accept && gives_result) begin
            r_out.found    <= r_match || match_set;
            r_out.overflow <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### tb/anagram_window_search_checker.sv
// ============================================================================
// anagram_window_search_checker
// Watches both channels of the anagram search. Every accepted letter runs
// through a local model of the pattern and window histograms. Every accepted
// result is compared, field by field, against the oldest outstanding verdict.
// ============================================================================
`timescale 1ns / 1ps

module anagram_window_search_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  aws_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  aws_pkg::t_out_item i_out_data,
    output int                 o_errors,
    output int                 o_pending
);

    import aws_pkg::*;

    logic [CNT_W-1:0]    pattern_hist [ALPHABET];
    logic [CNT_W-1:0]    window_hist  [ALPHABET];
    logic [LETTER_W-1:0] window_ring  [MAX_PATTERN];
    logic [POS_W-1:0]    ring_slot;
    logic [CNT_W-1:0]    pattern_len;
    logic [CNT_W-1:0]    window_fill;
    bit                  window_matched;
    bit                  pattern_overflow;

    t_out_item verdicts_due [$];
    int        mismatches       = 0;
    int        verdicts_pending = 0;

    assign o_errors  = mismatches;
    assign o_pending = verdicts_pending;

    task automatic clear_search();
        for (int k = 0; k < ALPHABET; k++) begin
            pattern_hist[k] = '0;
            window_hist[k]  = '0;
        end
        ring_slot        = '0;
        pattern_len      = '0;
        window_fill      = '0;
        window_matched   = 1'b0;
        pattern_overflow = 1'b0;
    endtask

    function automatic bit histograms_agree();
        for (int k = 0; k < ALPHABET; k++) begin
            if (pattern_hist[k] != window_hist[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic search_letter(input t_in_item item);
        logic [CNT_W-1:0]    next_slot;
        logic [LETTER_W-1:0] oldest;
        t_out_item           verdict;
        bit                  in_alpha;
        in_alpha = item.letter < ALPHABET;
        if (item.operation == OP_PATTERN) begin
            // pattern letters only count until the window has taken a letter
            if (in_alpha && window_fill == '0) begin
                if (pattern_len < MAX_PATTERN) begin
                    pattern_hist[item.letter]++;
                    pattern_len++;
                end else begin
                    pattern_overflow = 1'b1;
                end
            end
        end else begin
            if (in_alpha && pattern_len != '0) begin
                if (window_fill < pattern_len) begin
                    window_fill++;
                end else begin
                    oldest = window_ring[ring_slot];
                    if (oldest < ALPHABET && window_hist[oldest] != '0)
                        window_hist[oldest]--;
                end
                window_ring[ring_slot] = item.letter;
                window_hist[item.letter]++;
                next_slot = ring_slot;
                next_slot = next_slot + 1'b1;
                ring_slot = (next_slot >= pattern_len) ? '0 : next_slot[POS_W-1:0];
            end
            if (in_alpha && window_fill == pattern_len && histograms_agree())
                window_matched = 1'b1;
            if (item.last) begin
                if (window_fill == pattern_len && histograms_agree())
                    window_matched = 1'b1;
                verdict.found    = window_matched;
                verdict.overflow = pattern_overflow;
                verdicts_due.insert(verdicts_due.size(), verdict);
                clear_search();
            end
        end
    endtask

    task automatic compare_verdict(input t_out_item got);
        t_out_item want;
        if (verdicts_due.size() == 0) begin
            $display("%0t: result found=%0b overflow=%0b with none expected",
                     $time, got.found, got.overflow);
            mismatches++;
        end else begin
            want = verdicts_due.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found expected %0b actual %0b",
                         $time, want.found, got.found);
                mismatches++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow expected %0b actual %0b",
                         $time, want.overflow, got.overflow);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_search();
            verdicts_due.delete();
            verdicts_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) compare_verdict(i_out_data);
            if (i_in_valid && i_in_ready) search_letter(i_in_data);
            verdicts_pending <= verdicts_due.size();
        end
    end

endmodule

### tb/anagram_window_search_tb.sv
// ============================================================================
// anagram_window_search_tb
// Drives pattern and text letters into the anagram search: a directed set of
// corner queries, then random queries with planted anagrams, stray and
// out-of-range letters, and two full-capacity patterns. Both channels stall
// at random. A checker alongside the block predicts and compares results.
// ============================================================================
`timescale 1ns / 1ps

module anagram_window_search_tb;

    import aws_pkg::*;

    localparam int ITEM_TARGET  = 1700;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;
    int        errors;
    int        pending;

    int        idle_cycles = 0;
    int        items_sent  = 0;
    int        stall_left  = 0;
    int        free_left   = 0;
    bit        steady_feed = 1'b0;
    t_in_item  query_items [$];

    anagram_window_search dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    anagram_window_search_checker search_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: stretches of free flow broken by stalls
    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (free_left > 0) begin
            out_ready <= 1'b1;
            free_left <= free_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left <= pick_gap();
        end else begin
            free_left <= $urandom_range(1, 40);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("anagram_window_search_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_letter(input t_op op, input int letter, input bit last);
        t_in_item item;
        item.operation = op;
        item.letter    = LETTER_W'(letter);
        item.last      = last;
        query_items.insert(query_items.size(), item);
    endtask

    task automatic send_letter(input t_in_item item);
        int gap;
        gap = (!steady_feed && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_query();
        foreach (query_items[k]) send_letter(query_items[k]);
        query_items.delete();
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic build_query(input int plen, input int tlen, input int span,
                               input bit noisy, input bit plant);
        int base;
        int at;
        int j;
        int letter;
        int swap;
        int pat [$];
        int txt [$];
        base = $urandom_range(0, ALPHABET - span);
        for (int k = 0; k < plen; k++) begin
            pat.insert(pat.size(), base + $urandom_range(0, span - 1));
        end
        for (int k = 0; k < tlen; k++) begin
            txt.insert(txt.size(), base + $urandom_range(0, span - 1));
        end
        if (plant && plen > 0 && plen <= tlen) begin
            at = $urandom_range(0, tlen - plen);
            for (int k = 0; k < plen; k++) txt[at + k] = pat[k];
            for (int k = plen - 1; k > 0; k--) begin
                j            = $urandom_range(0, k);
                swap         = txt[at + k];
                txt[at + k]  = txt[at + j];
                txt[at + j]  = swap;
            end
        end
        for (int k = 0; k < plen; k++) begin
            letter = (noisy && $urandom_range(0, 24) == 0) ? $urandom_range(ALPHABET, 31)
                                                           : pat[k];
            queue_letter(OP_PATTERN, letter,
                         (k == plen - 1) ? $urandom_range(0, 1) == 1
                                         : $urandom_range(0, 31) == 0);
        end
        for (int k = 0; k < tlen; k++) begin
            if (noisy && $urandom_range(0, 29) == 0)
                queue_letter(OP_PATTERN, $urandom_range(0, 31), $urandom_range(0, 1) == 1);
            letter = (noisy && $urandom_range(0, 24) == 0) ? $urandom_range(ALPHABET, 31)
                                                           : txt[k];
            queue_letter(OP_TEXT, letter, k == tlen - 1);
        end
    endtask

    initial begin
        int query_no;
        int plen;
        int tlen;
        int roll;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty pattern: found on any text
        queue_letter(OP_TEXT, 25, 1'b1);
        // last bit on a pattern letter does not end the pattern
        queue_letter(OP_PATTERN, 0, 1'b1);
        queue_letter(OP_PATTERN, 1, 1'b0);
        queue_letter(OP_TEXT, 1, 1'b0);
        queue_letter(OP_TEXT, 0, 1'b1);
        // out-of-range letters dropped on both sides
        queue_letter(OP_PATTERN, 31, 1'b0);
        queue_letter(OP_PATTERN, 0, 1'b0);
        queue_letter(OP_TEXT, 26, 1'b0);
        queue_letter(OP_TEXT, 0, 1'b1);
        // short text, closed by an out-of-range letter
        queue_letter(OP_PATTERN, 2, 1'b0);
        queue_letter(OP_PATTERN, 2, 1'b0);
        queue_letter(OP_PATTERN, 3, 1'b0);
        queue_letter(OP_TEXT, 2, 1'b0);
        queue_letter(OP_TEXT, 3, 1'b0);
        queue_letter(OP_TEXT, 30, 1'b1);
        // pattern letter inside the text is ignored
        queue_letter(OP_PATTERN, 0, 1'b0);
        queue_letter(OP_TEXT, 1, 1'b0);
        queue_letter(OP_PATTERN, 1, 1'b0);
        queue_letter(OP_TEXT, 1, 1'b1);
        // empty pattern lets a late pattern letter in
        queue_letter(OP_TEXT, 2, 1'b0);
        queue_letter(OP_PATTERN, 3, 1'b0);
        queue_letter(OP_TEXT, 3, 1'b1);
        send_query();
        drain_results();

        query_no = 0;
        while (items_sent < ITEM_TARGET) begin
            steady_feed = ($urandom_range(0, 3) == 0);
            if (query_no == 6) begin
                // full-capacity pattern with an anagram planted in the text
                build_query(MAX_PATTERN, MAX_PATTERN + $urandom_range(0, 12),
                            $urandom_range(1, ALPHABET), 1'b0, 1'b1);
            end else if (query_no == 20) begin
                // pattern too long; one letter throughout so the kept part matches
                build_query(MAX_PATTERN + $urandom_range(1, 8),
                            MAX_PATTERN + $urandom_range(0, 4), 1, 1'b0, 1'b0);
            end else begin
                roll = $urandom_range(0, 99);
                plen = (roll < 5) ? 0 : (roll < 90) ? $urandom_range(1, 6)
                                                    : $urandom_range(7, 24);
                tlen = ($urandom_range(0, 32) == 0) ? 0 : $urandom_range(1, plen + 8);
                build_query(plen, tlen,
                            $urandom_range(0, 1) ? $urandom_range(1, 4)
                                                 : $urandom_range(1, ALPHABET),
                            1'b1, $urandom_range(0, 1) == 1);
            end
            send_query();
            if (query_no % 40 == 39) drain_results();
            query_no++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("anagram_window_search_tb OK");
        end else begin
            $display("anagram_window_search_tb NOT OK");
        end
        $finish;
    end

endmodule
